// ===== src/erm_pkg.sv =====
`timescale 1ns / 1ps
package erm_pkg;

  localparam int CHANNELS   = 1024;
  localparam int CH_BITS    = $clog2(CHANNELS);
  localparam int EPOCH_BITS = 32;
  localparam int FRAC_BITS  = 8;
  localparam int T_BITS     = 63;
  localparam int RATE_BITS  = 36;
  // 1e9 needs 30 bits; numerator is 1e9 << (16 + FRAC_BITS)
  localparam int NUM_BITS   = 30 + 16 + FRAC_BITS;

  localparam logic [2:0] MODE_DOC     = 3'd0;
  localparam logic [2:0] MODE_UPDATE  = 3'd1;
  localparam logic [2:0] MODE_QUERY   = 3'd2;
  localparam logic [2:0] MODE_MAX     = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;

  localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_STALE_FLOOR  = 2'd1;
  localparam logic [1:0] CFG_STALE_FACTOR = 2'd2;
  localparam logic [1:0] CFG_MAX_CACHE    = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EPOCH,
    OP_UPDATE,
    OP_QUERY,
    OP_MAX,
    OP_RELEASE
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  channel;
    logic [62:0] now_ns;
    logic        value_changed;
  } in_word_t;

  typedef struct packed {
    logic        entry_valid;
    logic [35:0] rate_q16;
    logic        is_stale;
    logic [62:0] since_change_ns;
  } out_word_t;

  typedef struct packed {
    op_t                op;
    logic [CH_BITS-1:0] idx;
    logic [62:0]        now_ns;
    logic               changed;
  } work_t;

  typedef struct packed {
    logic                  live;
    logic [1:0]            cnt;
    logic [EPOCH_BITS-1:0] tag;
    logic [62:0]           last_upd;
    logic [62:0]           last_chg;
    logic [63:0]           avg;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== src/erm_ram.sv =====
`timescale 1ns / 1ps
module erm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/erm_front.sv =====
`timescale 1ns / 1ps
module erm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  erm_pkg::in_word_t item,
  input  logic              hold,
  output logic              work_valid,
  output erm_pkg::work_t    work,
  input  logic              work_take
);
  import erm_pkg::*;

  work_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  work_t      cls;

  always_comb begin
    logic in_range;
    in_range    = 32'(item.channel) < CHANNELS;
    cls.idx     = item.channel[CH_BITS-1:0];
    cls.now_ns  = item.now_ns;
    cls.changed = item.value_changed;
    case (item.mode)
      MODE_DOC:     cls.op = OP_EPOCH;
      MODE_UPDATE:  cls.op = in_range ? OP_UPDATE : OP_NONE;
      MODE_QUERY:   cls.op = in_range ? OP_QUERY : OP_NONE;
      MODE_MAX:     cls.op = OP_MAX;
      MODE_RELEASE: cls.op = in_range ? OP_RELEASE : OP_NONE;
      default:      cls.op = OP_NONE;
    endcase
  end

  assign full       = hold || (count == 2'd2);
  assign accept     = push && !full;
  assign work_valid = (count != 2'd0);
  assign work       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (work_take && work_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(work_take && work_valid);
    end
  end

endmodule

// ===== src/erm_div.sv =====
`timescale 1ns / 1ps
module erm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [63:0]                  denom,
  output logic                         done,
  output logic [erm_pkg::NUM_BITS-1:0] quot
);
  import erm_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);
  localparam logic [NUM_BITS-1:0] RATE_NUM = NUM_BITS'(1000000000) << (16 + FRAC_BITS);

  logic [63:0]         rem;
  logic [63:0]         den;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [64:0]         trial;
  logic                fits;

  // restoring division, one quotient bit a cycle; dividend shifts out of quot
  assign trial = {rem, quot[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      den  <= denom;
      quot <= RATE_NUM;
    end else if (busy) begin
      rem  <= fits ? 64'(trial - {1'b0, den}) : trial[63:0];
      quot <= {quot[NUM_BITS-2:0], fits};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/erm_back.sv =====
`timescale 1ns / 1ps
module erm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_valid,
  input  erm_pkg::work_t     work,
  output logic               work_take,
  output logic               clearing,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output erm_pkg::out_word_t result
);
  import erm_pkg::*;

  localparam int WHOLE_BITS = 64 - FRAC_BITS;

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_EXEC     = 13'b0000000000100,
    S_UPD      = 13'b0000000001000,
    S_Q2       = 13'b0000000010000,
    S_Q3       = 13'b0000000100000,
    S_DIV      = 13'b0000001000000,
    S_MAX0     = 13'b0000010000000,
    S_SCAN_RD  = 13'b0000100000000,
    S_SCAN_A   = 13'b0001000000000,
    S_SCAN_B   = 13'b0010000000000,
    S_SCAN_END = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  function automatic logic [63:0] shl_sat(input logic [62:0] v);
    logic [63+FRAC_BITS:0] w;
    w = (64 + FRAC_BITS)'(v) << FRAC_BITS;
    if ((w >> 64) != '0) return '1;
    return w[63:0];
  endfunction

  function automatic logic [62:0] sub_clamp(input logic [62:0] a, input logic [62:0] b);
    return (a > b) ? 63'(a - b) : '0;
  endfunction

  state_t                 state;
  work_t                  cur;
  entry_t                 e;
  entry_t                 rd;
  entry_t                 upd;
  entry_t                 base;
  out_word_t              res;
  logic [19:0]            min_interval;
  logic [39:0]            stale_floor;
  logic [7:0]             stale_factor;
  logic [31:0]            max_cache;
  logic [EPOCH_BITS-1:0]  epoch;
  logic [RATE_BITS-1:0]   cached_rate;
  logic [62:0]            cached_at;
  logic                   cache_valid;
  logic [CH_BITS-1:0]     clr_idx;
  logic [CH_BITS-1:0]     scan_idx;
  logic [62:0]            idle;
  logic [62:0]            since;
  logic [63:0]            d;
  logic [63:0]            denom;
  logic [71:0]            prod;
  logic                   rate_zero;
  logic                   found;
  logic                   out_valid;
  logic                   ram_we;
  logic [CH_BITS-1:0]     ram_waddr;
  logic [CH_BITS-1:0]     ram_raddr;
  logic [ENTRY_BITS-1:0]  ram_wdata;
  logic [ENTRY_BITS-1:0]  ram_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [NUM_BITS-1:0]    quot;
  logic [RATE_BITS-1:0]   quot_sat;
  logic [62:0]            dt;
  logic [62:0]            cache_diff;
  logic [63:0]            scan_den;
  logic [71:0]            thr;
  logic [WHOLE_BITS-1:0]  whole;

  assign rd        = entry_t'(ram_rdata);
  assign clearing  = (state == S_CLEAR);
  assign work_take = (state == S_IDLE) && work_valid;
  assign empty     = !out_valid;
  assign ram_raddr = (state == S_IDLE) ? work.idx : scan_idx;
  assign quot_sat  = ((quot >> RATE_BITS) != '0) ? '1 : quot[RATE_BITS-1:0];
  assign div_start = ((state == S_Q3) && !rate_zero) || ((state == S_SCAN_END) && found);
  assign whole     = e.avg[63:FRAC_BITS];

  // an entry that is not live starts over before the update is counted
  always_comb begin
    base = rd;
    if (!rd.live) begin
      base.live     = 1'b1;
      base.cnt      = 2'd0;
      base.tag      = epoch + 1'b1;
      base.last_upd = cur.now_ns;
      base.last_chg = cur.now_ns;
      base.avg      = '0;
    end
    dt = sub_clamp(cur.now_ns, base.last_upd);
    if (dt < 63'(min_interval)) dt = 63'(min_interval);
  end

  always_comb begin
    logic [65:0] mix;
    mix = 66'(e.avg) + 66'({e.avg, 1'b0}) + 66'(d);
    upd = e;
    if (e.tag != epoch) begin
      upd.tag = epoch;
      if (e.cnt == 2'd0) begin
        upd.last_upd = cur.now_ns;
        upd.last_chg = cur.now_ns;
      end else begin
        upd.avg      = (e.cnt == 2'd1) ? d : mix[65:2];
        upd.last_upd = cur.now_ns;
      end
      if (e.cnt != 2'd2) upd.cnt = e.cnt + 1'b1;
    end
    if (cur.changed) upd.last_chg = cur.now_ns;
    upd.live = 1'b1;
  end

  always_comb begin
    scan_den   = shl_sat(idle);
    if (e.avg > scan_den) scan_den = e.avg;
    thr        = (prod > 72'(stale_floor)) ? prod : 72'(stale_floor);
    cache_diff = (cur.now_ns >= cached_at) ? 63'(cur.now_ns - cached_at)
                                           : 63'(cached_at - cur.now_ns);
  end

  always_comb begin
    entry_t rel;
    rel         = rd;
    rel.live    = 1'b0;
    rel.cnt     = 2'd0;
    ram_we      = 1'b0;
    ram_waddr   = cur.idx;
    ram_wdata   = upd;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_UPD: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        if (cur.op == OP_RELEASE && rd.live) begin
          ram_we    = 1'b1;
          ram_wdata = rel;
        end
      end
      default: begin
      end
    endcase
  end

  erm_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  erm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      min_interval <= 20'd1000;
      stale_floor  <= 40'd3000000000;
      stale_factor <= 8'd20;
      max_cache    <= 32'd200000000;
      epoch        <= '0;
      cached_rate  <= '0;
      cached_at    <= '0;
      cache_valid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: min_interval <= cfg_data[19:0];
          CFG_STALE_FLOOR:  stale_floor  <= cfg_data;
          CFG_STALE_FACTOR: stale_factor <= cfg_data[7:0];
          CFG_MAX_CACHE:    max_cache    <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (state == S_DONE && (!out_valid || pop)) out_valid <= 1'b1;
      else if (pop && out_valid)                  out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CH_BITS'(CHANNELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (work_valid) begin
            cur <= work;
            res <= '0;
            case (work.op)
              OP_EPOCH: begin
                epoch <= epoch + 1'b1;
                state <= S_DONE;
              end
              OP_MAX:                         state <= S_MAX0;
              OP_UPDATE, OP_QUERY, OP_RELEASE: state <= S_EXEC;
              default:                        state <= S_DONE;
            endcase
          end
        end
        S_EXEC: begin
          case (cur.op)
            OP_UPDATE: begin
              e     <= base;
              d     <= shl_sat(dt);
              state <= S_UPD;
            end
            OP_QUERY: begin
              e     <= rd;
              idle  <= sub_clamp(cur.now_ns, rd.last_upd);
              since <= sub_clamp(cur.now_ns, rd.last_chg);
              state <= rd.live ? S_Q2 : S_DONE;
            end
            default: begin
              if (rd.live) cache_valid <= 1'b0;
              state <= S_DONE;
            end
          endcase
        end
        S_UPD: begin
          if (e.tag != epoch) cache_valid <= 1'b0;
          state <= S_DONE;
        end
        S_Q2: begin
          denom     <= scan_den;
          prod      <= 72'(whole) * 72'(stale_factor);
          rate_zero <= (e.cnt < 2'd2) || (e.avg == '0);
          state     <= S_Q3;
        end
        S_Q3: begin
          res.entry_valid     <= 1'b1;
          res.since_change_ns <= since;
          if (e.cnt == 2'd0)   res.is_stale <= 1'b1;
          else if (idle == '0) res.is_stale <= 1'b0;
          else                 res.is_stale <= 72'(idle) > thr;
          state <= rate_zero ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res.rate_q16 <= quot_sat;
            if (cur.op == OP_MAX) begin
              cached_rate <= quot_sat;
              cached_at   <= cur.now_ns;
              cache_valid <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_MAX0: begin
          if (cache_valid && cache_diff < 63'(max_cache)) begin
            res.rate_q16 <= cached_rate;
            state        <= S_DONE;
          end else begin
            scan_idx <= '0;
            denom    <= '1;
            found    <= 1'b0;
            state    <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_A;
        S_SCAN_A: begin
          e     <= rd;
          idle  <= sub_clamp(cur.now_ns, rd.last_upd);
          state <= S_SCAN_B;
        end
        S_SCAN_B: begin
          // highest rate comes from the smallest divisor
          if (e.live && e.cnt == 2'd2 && e.avg != '0) begin
            found <= 1'b1;
            if (scan_den < denom) denom <= scan_den;
          end
          if (scan_idx == CH_BITS'(CHANNELS - 1)) begin
            state <= S_SCAN_END;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_SCAN_END: begin
          if (found) begin
            state <= S_DIV;
          end else begin
            cached_rate <= '0;
            cached_at   <= cur.now_ns;
            cache_valid <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/event_rate_meter_table_top.sv =====
`timescale 1ns / 1ps
// A channel query ends in a division when the entry has a rate; a maximum query that misses
// the cache reads every table entry in turn, then divides if any entry has a rate.
// Throughput: one word at a time through the table sequencer; the input queue holds two.
// Reset: synchronous, active high; then a clearing pass over all 1024 table entries,
// during which full stays high. Config writes are taken at any time outside reset.
module event_rate_meter_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  erm_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output erm_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data
);
  import erm_pkg::*;

  work_t work;
  logic  work_valid;
  logic  work_take;
  logic  clearing;

  assign cfg_ready = 1'b1;

  erm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .hold       (clearing),
    .work_valid (work_valid),
    .work       (work),
    .work_take  (work_take)
  );

  erm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .work_take  (work_take),
    .clearing   (clearing),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== bench/tb_event_rate_meter_table_top.sv =====
`timescale 1ns / 1ps
module tb_event_rate_meter_table_top;
  import erm_pkg::*;

  localparam longint unsigned SAT64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned T_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned RMAX   = (64'd1 << 36) - 1;
  localparam int DRAIN_CYCLES = 3300;  // longest word: a maximum query over the table

  class rate_scoreboard;
    longint unsigned min_iv, floor_ns, factor, cache_win;
    bit              chan_live [CHANNELS];
    bit [1:0]        upd_cnt   [CHANNELS];
    bit [31:0]       tag       [CHANNELS];
    longint unsigned last_upd  [CHANNELS];
    longint unsigned last_chg  [CHANNELS];
    longint unsigned avg       [CHANNELS];
    bit [31:0]       epoch;
    longint unsigned cmax, cat;
    bit              cvalid;
    out_word_t       expected_q[$];
    int              errors, checked;

    function new();
      min_iv = 1000; floor_ns = 64'd3000000000; factor = 20; cache_win = 200000000;
      foreach (chan_live[i]) begin
        chan_live[i] = 0;
        upd_cnt[i] = 0;
      end
      epoch = 0; cmax = 0; cat = 0; cvalid = 0;
      errors = 0; checked = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [39:0] val);
      case (idx)
        CFG_MIN_INTERVAL: min_iv = val[19:0];
        CFG_STALE_FLOOR:  floor_ns = val;
        CFG_STALE_FACTOR: factor = val[7:0];
        CFG_MAX_CACHE:    cache_win = val[31:0];
        default: ;
      endcase
    endfunction

    function longint unsigned shift_frac(longint unsigned v);
      if (v > (SAT64 >> FRAC_BITS)) return SAT64;
      return v << FRAC_BITS;
    endfunction

    function longint unsigned rate_at(int ch, longint unsigned now);
      longint unsigned idle, den, r;
      if (upd_cnt[ch] < 2 || avg[ch] == 0) return 0;
      idle = (now > last_upd[ch]) ? now - last_upd[ch] : 0;
      den = shift_frac(idle);
      if (avg[ch] > den) den = avg[ch];
      r = (64'd1000000000 << (16 + FRAC_BITS)) / den;
      return (r > RMAX) ? RMAX : r;
    endfunction

    function bit stale_at(int ch, longint unsigned now);
      longint unsigned whole, thr;
      if (upd_cnt[ch] == 0) return 1;
      if (now <= last_upd[ch]) return 0;
      whole = avg[ch] >> FRAC_BITS;
      if (factor != 0 && whole > SAT64 / factor) thr = SAT64;
      else thr = whole * factor;
      if (floor_ns > thr) thr = floor_ns;
      return (now - last_upd[ch]) > thr;
    endfunction

    function void count_update(int ch, longint unsigned now);
      longint unsigned dt, d, a;
      if (tag[ch] == epoch) return;
      tag[ch] = epoch;
      if (upd_cnt[ch] == 0) begin
        last_upd[ch] = now;
        last_chg[ch] = now;
      end else begin
        dt = (now > last_upd[ch]) ? now - last_upd[ch] : 0;
        if (dt < min_iv) dt = min_iv;
        d = shift_frac(dt);
        if (upd_cnt[ch] == 1) avg[ch] = d;
        else begin
          a = avg[ch];
          avg[ch] = (a >> 2) * 3 + (d >> 2) + (((a & 3) * 3 + (d & 3)) >> 2);
        end
        last_upd[ch] = now;
      end
      if (upd_cnt[ch] < 2) upd_cnt[ch]++;
      cvalid = 0;
    endfunction

    function void note_input(in_word_t w);
      out_word_t       o;
      int              ch;
      longint unsigned now, diff, top, r;
      o = '0;
      ch = int'(w.channel);
      now = 64'(w.now_ns);
      case (w.mode)
        MODE_DOC: epoch = epoch + 1;
        MODE_UPDATE: begin
          if (!chan_live[ch]) begin
            chan_live[ch] = 1;
            upd_cnt[ch] = 0;
            tag[ch] = epoch + 1;
            last_upd[ch] = now;
            last_chg[ch] = now;
            avg[ch] = 0;
          end
          count_update(ch, now);
          if (w.value_changed) last_chg[ch] = now;
        end
        MODE_QUERY: if (chan_live[ch]) begin
          o.entry_valid = 1;
          o.rate_q16 = 36'(rate_at(ch, now));
          o.is_stale = stale_at(ch, now);
          o.since_change_ns = 63'((now > last_chg[ch]) ? now - last_chg[ch] : 0);
        end
        MODE_MAX: begin
          diff = (now >= cat) ? now - cat : cat - now;
          if (cvalid && diff < cache_win) o.rate_q16 = 36'(cmax);
          else begin
            top = 0;
            for (int i = 0; i < CHANNELS; i++) begin
              if (chan_live[i]) begin
                r = rate_at(i, now);
                if (r > top) top = r;
              end
            end
            cmax = top; cat = now; cvalid = 1;
            o.rate_q16 = 36'(top);
          end
        end
        MODE_RELEASE: if (chan_live[ch]) begin
          chan_live[ch] = 0;
          upd_cnt[ch] = 0;
          cvalid = 0;
        end
        default: ;
      endcase
      expected_q.push_back(o);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing expected: %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.entry_valid !== e.entry_valid || got.rate_q16 !== e.rate_q16 ||
          got.is_stale !== e.is_stale || got.since_change_ns !== e.since_change_ns) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d valid %0b/%0b rate %0d/%0d stale %0b/%0b since %0d/%0d",
                   checked, got.entry_valid, e.entry_valid, got.rate_q16, e.rate_q16,
                   got.is_stale, e.is_stale, got.since_change_ns, e.since_change_ns);
      end
    endfunction
  endclass

  logic       clk, rst, push, full, empty, pop, cfg_valid, cfg_ready;
  in_word_t   item;
  out_word_t  result;
  logic [1:0] cfg_index;
  logic [39:0] cfg_data;

  rate_scoreboard  sb;
  bit              no_idle;
  int              hold_cycles;
  int              mode_seen [8];
  longint unsigned t_now;

  event_rate_meter_table_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    int burst;
    burst = 0;
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 0;
      end else if (burst > 0) begin
        burst--;
        pop <= 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        pop <= 0;
      end else pop <= 1;
    end
  end

  always @(posedge clk)
    if (!rst && pop && !empty) sb.check_result(result);

  task automatic send_word(in_word_t w);
    int gap;
    @(negedge clk);
    push <= 1;
    item <= w;
    do @(posedge clk); while (full);
    sb.note_input(w);
    mode_seen[w.mode]++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      push <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] m, int ch, longint unsigned now, bit chg);
    in_word_t w;
    w.mode = m;
    w.channel = 10'(ch);
    w.now_ns = now[62:0];
    w.value_changed = chg;
    send_word(w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_word();
    int  pick, ch;
    logic [2:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 45) m = MODE_UPDATE;
    else if (pick < 70) m = MODE_QUERY;
    else if (pick < 83) m = MODE_DOC;
    else if (pick < 93) m = MODE_RELEASE;
    else if (pick < 96) m = MODE_MAX;
    else m = 3'($urandom_range(5, 7));
    ch = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    pick = $urandom_range(0, 99);
    if (pick < 3) t_now = t_now - $urandom_range(0, 100000000);
    else if (pick < 4) t_now = {$urandom, $urandom};
    else if (pick < 40) t_now = t_now + $urandom_range(0, 2000);
    else if (pick < 85) t_now = t_now + $urandom_range(0, 10000000);
    else t_now = t_now + longint'($urandom_range(0, 10000)) * 1000000;
    t_now &= T_MASK;
    send_op(m, ch, t_now, $urandom_range(0, 1));
  endtask

  initial begin
    sb = new();
    rst = 1; push = 0; item = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    no_idle = 0; hold_cycles = 0; t_now = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: clamp, same-epoch repeat, cache hit, time backwards, odd modes, extremes
    send_op(MODE_UPDATE, 0, 1000, 1);
    send_op(MODE_DOC, 0, 0, 0);
    send_op(MODE_UPDATE, 0, 1500, 0);
    send_op(MODE_DOC, 0, 0, 0);
    send_op(MODE_UPDATE, 0, 5000, 0);
    send_op(MODE_UPDATE, 0, 9000, 1);
    send_op(MODE_QUERY, 0, 20000, 0);
    send_op(MODE_QUERY, 1023, 20000, 0);
    send_op(MODE_UPDATE, 1023, 30000, 1);
    send_op(MODE_MAX, 0, 40000, 0);
    send_op(MODE_MAX, 0, 40001, 0);
    send_op(MODE_QUERY, 0, 100, 0);
    send_op(MODE_QUERY, 0, 64'd9000000000, 0);
    send_op(MODE_RELEASE, 0, 0, 0);
    send_op(MODE_RELEASE, 0, 0, 0);
    send_op(MODE_QUERY, 0, 50000, 0);
    send_op(3'd5, 1023, T_MASK, 1);
    send_op(3'd6, 0, 0, 0);
    send_op(3'd7, 1023, T_MASK, 1);
    send_op(MODE_DOC, 0, 0, 0);
    send_op(MODE_UPDATE, 1023, T_MASK, 1);
    send_op(MODE_QUERY, 1023, T_MASK, 0);
    send_op(MODE_QUERY, 1023, 0, 0);
    send_op(MODE_MAX, 0, T_MASK, 0);
    t_now = 60000;

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) begin
        write_reg(CFG_MIN_INTERVAL, 40'd1);
        write_reg(CFG_STALE_FLOOR, 40'd0);
        write_reg(CFG_STALE_FACTOR, 40'd1);
        write_reg(CFG_MAX_CACHE, 40'd0);
      end else if (phase == 2) begin
        write_reg(CFG_MIN_INTERVAL, 40'd1000000);
        write_reg(CFG_STALE_FLOOR, 40'hFF_FFFF_FFFF);
        write_reg(CFG_STALE_FACTOR, 40'd255);
        write_reg(CFG_MAX_CACHE, 40'hFFFF_FFFF);
      end else if (phase == 3) begin
        write_reg(CFG_MIN_INTERVAL, 40'($urandom_range(1, 1000000)));
        write_reg(CFG_STALE_FLOOR, {8'($urandom), 32'($urandom)});
        write_reg(CFG_STALE_FACTOR, 40'($urandom_range(1, 255)));
        write_reg(CFG_MAX_CACHE, 40'($urandom));
      end
      for (int n = 0; n < 495; n++) begin
        if (phase == 2 && n == 100) hold_cycles = 600;  // let the block back up
        if (phase == 3 && n == 250) no_idle = 1;
        random_word();
      end
      drain();
    end

    $display("Covered %0d words: doc %0d, update %0d, query %0d, max %0d, release %0d",
             mode_seen.sum(), mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             mode_seen[4]);
    $display("Four register settings incl. both extremes; %0d results checked, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/erm_pkg.sv
src/erm_ram.sv
src/erm_front.sv
src/erm_div.sv
src/erm_back.sv
src/event_rate_meter_table_top.sv
bench/tb_event_rate_meter_table_top.sv
